### hdl/rgbc_pkg.sv
package rgbc_pkg;

	localparam int MAX_WIDTH = 2048;
	localparam int AW = $clog2(MAX_WIDTH);
	localparam int CW = 12;
	localparam int PAW = 5;

	// register indexes
	localparam logic [2:0] REG_K_TOP = 3'd0;
	localparam logic [2:0] REG_K_MID = 3'd1;
	localparam logic [2:0] REG_K_BOT = 3'd2;
	localparam logic [2:0] REG_DIV   = 3'd3;
	localparam logic [2:0] REG_THR   = 3'd4;
	localparam logic [2:0] REG_WIDTH = 3'd5;
	localparam logic [2:0] REG_HEIGHT = 3'd6;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [7:0]  out_red;
		logic [7:0]  out_green;
		logic [7:0]  out_blue;
		logic        edge_flag;
		logic [10:0] center_x;
		logic [11:0] center_y;
		logic        last_in_frame;
	} pix_out_t;

	typedef struct packed {
		logic [23:0] k_top;
		logic [23:0] k_mid;
		logic [23:0] k_bot;
		logic [7:0]  divisor;
		logic [7:0]  threshold;
		logic [11:0] width;
		logic [11:0] height;
	} cfg_t;

	// window handed to the arithmetic: nine pixels plus position tags
	typedef struct packed {
		logic [8:0][23:0] px;
		logic [10:0]      cx;
		logic [11:0]      cy;
		logic             last;
	} win_t;

endpackage

### hdl/rgbc_if.sv
interface rgbc_in_if import rgbc_pkg::*; (input logic clk);
	logic    valid;
	logic    ready;
	pix_in_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface rgbc_out_if import rgbc_pkg::*; (input logic clk);
	logic     valid;
	logic     ready;
	pix_out_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

### hdl/rgbc_regs.sv
module rgbc_regs import rgbc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            psel,
	input  logic            penable,
	input  logic            pwrite,
	input  logic [PAW-1:0]  paddr,
	input  logic [31:0]     pwdata,
	output logic [31:0]     prdata,
	output logic            pready,
	output cfg_t            cfg
);
	logic [2:0] idx;
	logic       wr;
	cfg_t       cfg_q;

	assign idx = paddr[PAW-1:2];
	assign wr = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.k_top <= 24'd256;
			cfg_q.k_mid <= 24'd130049;
			cfg_q.k_bot <= 24'd256;
			cfg_q.divisor <= 8'd1;
			cfg_q.threshold <= 8'd30;
			cfg_q.width <= 12'd640;
			cfg_q.height <= 12'd480;
		end else if (wr) begin
			case (idx)
				REG_K_TOP:  cfg_q.k_top <= pwdata[23:0];
				REG_K_MID:  cfg_q.k_mid <= pwdata[23:0];
				REG_K_BOT:  cfg_q.k_bot <= pwdata[23:0];
				REG_DIV:    cfg_q.divisor <= pwdata[7:0];
				REG_THR:    cfg_q.threshold <= pwdata[7:0];
				REG_WIDTH:  cfg_q.width <= pwdata[11:0];
				REG_HEIGHT: cfg_q.height <= pwdata[11:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		prdata = '0;
		case (idx)
			REG_K_TOP:  prdata = {8'd0, cfg_q.k_top};
			REG_K_MID:  prdata = {8'd0, cfg_q.k_mid};
			REG_K_BOT:  prdata = {8'd0, cfg_q.k_bot};
			REG_DIV:    prdata = {24'd0, cfg_q.divisor};
			REG_THR:    prdata = {24'd0, cfg_q.threshold};
			REG_WIDTH:  prdata = {20'd0, cfg_q.width};
			REG_HEIGHT: prdata = {20'd0, cfg_q.height};
			default:    prdata = '0;
		endcase
	end
endmodule

### hdl/rgbc_window.sv
module rgbc_window import rgbc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  cfg_t   cfg,
	input  logic   in_valid,
	input  pix_in_t in_data,
	output logic   in_ready,
	output logic   win_valid,
	output win_t   win,
	input  logic   win_ready
);
	// two line stores in one memory: each entry holds {upper, lower}
	logic [47:0]   mem [MAX_WIDTH];
	logic [47:0]   rd_s2;
	logic [AW-1:0] addr_s1;
	logic [23:0]   pix_s1;
	logic          v_s1;
	logic          res_s1;
	logic [10:0]   cx_s1;
	logic [11:0]   cy_s1;
	logic          last_s1;
	logic [10:0]   col_q;
	logic [11:0]   row_q;
	logic [11:0]   w_eff;
	logic [11:0]   h_eff;
	logic [10:0]   c;
	logic [11:0]   r;
	logic [11:0]   c_nx;
	logic [11:0]   r_nx;
	logic [2:0][2:0][23:0] win_q;
	logic          wv_q;
	win_t          wout_q;
	logic          acc;
	logic          fwd;
	logic [47:0]   rd_eff;
	logic [47:0]   wr_s2;
	logic [AW-1:0] addr_s2;
	logic          v_s2;

	always_comb begin
		w_eff = cfg.width;
		if (w_eff < 12'd3) w_eff = 12'd3;
		if (w_eff > 12'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
		h_eff = (cfg.height < 12'd3) ? 12'd3 : cfg.height;
	end

	// stall while a finished window waits, and in the cycle after an interior
	// pixel is accepted, so that the window register is always free for the item in stage 1
	assign in_ready = !(wv_q && !win_ready) && !(v_s1 && res_s1);
	assign acc = in_valid && in_ready;

	// position of the incoming pixel
	always_comb begin
		c = in_data.frame_start ? 11'd0 : col_q;
		r = in_data.frame_start ? 12'd0 : row_q;
		if ({1'b0, c} >= w_eff) c = 11'd0;
		if (r >= h_eff) r = 12'd0;
		c_nx = {1'b0, c} + 12'd1;
		r_nx = r;
		if (c_nx >= w_eff) begin
			c_nx = 12'd0;
			r_nx = r + 12'd1;
			if (r_nx >= h_eff) r_nx = 12'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= acc;
			if (acc) begin
				col_q <= c_nx[10:0];
				row_q <= r_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1 <= c[AW-1:0];
			pix_s1 <= {in_data.red, in_data.green, in_data.blue};
			res_s1 <= (c >= 11'd2) && (r >= 12'd2);
			cx_s1 <= c - 11'd1;
			cy_s1 <= r - 12'd1;
			last_s1 <= ({1'b0, c} == w_eff - 12'd1) && (r == h_eff - 12'd1);
		end
	end

	// memory read on accept, written back in the next cycle
	always_ff @(posedge clk) begin
		if (acc) rd_s2 <= mem[c[AW-1:0]];
		if (v_s1) mem[addr_s1] <= {rd_eff[23:0], pix_s1};
	end

	// forward the write of the previous item when it hits the same column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else v_s2 <= v_s1 && acc && (addr_s1 == c[AW-1:0]);
	end
	always_ff @(posedge clk) begin
		wr_s2 <= {rd_eff[23:0], pix_s1};
		addr_s2 <= addr_s1;
	end
	assign fwd = v_s2;
	assign rd_eff = fwd ? wr_s2 : rd_s2;

	// shift window and publish
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			wv_q <= 1'b0;
		end else begin
			wv_q <= (wv_q && !win_ready) || (v_s1 && res_s1);
			if (v_s1) begin
				for (int i = 0; i < 3; i++) begin
					win_q[i][0] <= win_q[i][1];
					win_q[i][1] <= win_q[i][2];
				end
				win_q[0][2] <= rd_eff[47:24];
				win_q[1][2] <= rd_eff[23:0];
				win_q[2][2] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1 && res_s1) begin
			wout_q.px <= {win_q[0][1], win_q[0][2], rd_eff[47:24],
				win_q[1][1], win_q[1][2], rd_eff[23:0],
				win_q[2][1], win_q[2][2], pix_s1};
			wout_q.cx <= cx_s1;
			wout_q.cy <= cy_s1;
			wout_q.last <= last_s1;
		end
	end

	assign win_valid = wv_q;
	assign win = wout_q;

	// a window is only published into an empty window register
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && res_s1) |-> !wv_q) else $error("window overrun");
	a_fwd_addr: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (addr_s2 == addr_s1)) else $error("forward mismatch");
	a_acc_ready: assert property (@(posedge clk) disable iff (!arst_n)
		acc |-> in_ready) else $error("accept without ready");
endmodule

### hdl/rgbc_arith.sv
module rgbc_arith import rgbc_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     win_valid,
	input  win_t     win,
	output logic     win_ready,
	output logic     out_valid,
	output pix_out_t out_data,
	input  logic     out_ready
);
	// sequencer: load, multiply-accumulate over 9 taps, divide 19 steps, finish
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MAC = 2'd1;
	localparam logic [1:0] ST_DIV = 2'd2;
	localparam logic [1:0] ST_OUT = 2'd3;

	logic [1:0]  st_q;
	logic [3:0]  tap_q;
	logic [4:0]  bit_q;
	win_t        w_q;
	logic [2:0][19:0] acc_q;
	logic [2:0][18:0] quo_q;
	logic [2:0][18:0] rem_q;
	logic [2:0][18:0] mag_q;
	logic [2:0]  neg_q;
	logic        ov_q;
	pix_out_t    o_q;
	logic [71:0] kall;
	logic signed [7:0] kc;
	logic [23:0] px;
	logic [2:0][7:0] res;
	logic [2:0][19:0] sgn;
	logic [2:0][19:0] rem_sh;

	assign win_ready = (st_q == ST_IDLE);
	assign kall = {cfg.k_bot, cfg.k_mid, cfg.k_top};
	// tap t = 3*i+j uses pixel window[2-i][2-j], stored at index t
	assign kc = kall[tap_q*8 +: 8];
	assign px = w_q.px[tap_q];

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			rem_sh[ch] = {rem_q[ch], mag_q[ch][18]};
			sgn[ch] = acc_q[ch];
			res[ch] = 8'd0;
		end
		for (int ch = 0; ch < 3; ch++) begin
			if (!neg_q[ch] && quo_q[ch] != 19'd0)
				res[ch] = (quo_q[ch] > 19'd255) ? 8'd255 : quo_q[ch][7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ov_q <= 1'b0;
		end else begin
			ov_q <= (ov_q && !out_ready) || ((st_q == ST_OUT) && (!ov_q || out_ready));
			case (st_q)
				ST_IDLE: if (win_valid) st_q <= ST_MAC;
				ST_MAC: if (tap_q == 4'd8) st_q <= ST_DIV;
				ST_DIV: if (bit_q == 5'd0) st_q <= ST_OUT;
				ST_OUT: if (!ov_q || out_ready) st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				w_q <= win;
				tap_q <= 4'd0;
				acc_q <= '0;
			end
			ST_MAC: begin
				for (int ch = 0; ch < 3; ch++)
					acc_q[ch] <= acc_q[ch] + 20'(signed'(kc) *
						signed'({1'b0, px[ch*8 +: 8]}));
				tap_q <= tap_q + 4'd1;
				if (tap_q == 4'd8) begin
					bit_q <= 5'd18;
					for (int ch = 0; ch < 3; ch++) begin
						rem_q[ch] <= '0;
						quo_q[ch] <= '0;
					end
				end
			end
			ST_DIV: begin
				// restoring division of |sum| by divisor (1 when <=1)
				for (int ch = 0; ch < 3; ch++) begin
					if (bit_q == 5'd18) begin
						neg_q[ch] <= sgn[ch][19];
						mag_q[ch] <= sgn[ch][19] ? 19'(-sgn[ch]) : sgn[ch][18:0];
					end else begin
						if (rem_sh[ch] >= 20'(cfg.divisor > 8'd1 ? cfg.divisor : 8'd1)) begin
							rem_q[ch] <= 19'(rem_sh[ch] -
								20'(cfg.divisor > 8'd1 ? cfg.divisor : 8'd1));
							quo_q[ch] <= {quo_q[ch][17:0], 1'b1};
						end else begin
							rem_q[ch] <= rem_sh[ch][18:0];
							quo_q[ch] <= {quo_q[ch][17:0], 1'b0};
						end
						mag_q[ch] <= {mag_q[ch][17:0], 1'b0};
					end
				end
				if (bit_q == 5'd18) bit_q <= 5'd19;
				else if (bit_q == 5'd19) bit_q <= 5'd17;
				else bit_q <= bit_q - 5'd1;
			end
			ST_OUT: if (!ov_q || out_ready) begin
				o_q.out_red <= res[2];
				o_q.out_green <= res[1];
				o_q.out_blue <= res[0];
				o_q.edge_flag <= (res[2] > cfg.threshold) || (res[1] > cfg.threshold)
					|| (res[0] > cfg.threshold);
				o_q.center_x <= w_q.cx;
				o_q.center_y <= w_q.cy;
				o_q.last_in_frame <= w_q.last;
			end
			default: ;
		endcase
	end

	assign out_valid = ov_q;
	assign out_data = o_q;

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !win_ready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> ov_q) else $error("result dropped");
	a_mac_end: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_MAC && tap_q == 4'd8) |=> st_q == ST_DIV) else $error("mac end");
endmodule

### hdl/rgb_3x3_convolution_clamp.sv
// RGB 3x3 convolution with clamp.
// Pixels enter in raster order on the pix_in channel (valid/ready); each
// interior centre gives one item on pix_out, border pixels give none.
// Configuration through the APB port: kernel rows, divisor, threshold and
// frame size at byte addresses 0x00..0x18; write only while idle.
// From the accepting edge of an interior pixel to its result valid, the
// line memory is read, the window is published, then the arithmetic unit
// takes it and runs 9 multiply-accumulate steps, a sign load, 19 restoring
// divide steps and one output step.
// Results are paced by the serial multiply-accumulate and divide sequence;
// the arithmetic unit takes no new window until its result is issued.
// Border pixels pass at one a cycle; an interior pixel drops pix_in ready
// for the next cycle; ready stays low while a window waits for that unit.
// The line memory holds two lines as one 48-bit word per column, read on
// accept and written back the next cycle, with forwarding for same-column
// reuse. Reset clears position, window and handshake state; line memory
// contents are undefined until the first two lines have been written.
// When pix_out stalls the result is held and the pipeline backs up to
// pix_in ready.
module rgb_3x3_convolution_clamp import rgbc_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	rgbc_in_if.sink        pix_in,
	rgbc_out_if.source     pix_out,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [PAW-1:0] paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	cfg_t cfg;
	logic wv;
	win_t wd;
	logic wr;

	rgbc_regs u_regs (.clk, .arst_n, .psel, .penable, .pwrite, .paddr, .pwdata,
		.prdata, .pready, .cfg);

	rgbc_window u_win (.clk, .arst_n, .cfg, .in_valid(pix_in.valid),
		.in_data(pix_in.data), .in_ready(pix_in.ready), .win_valid(wv),
		.win(wd), .win_ready(wr));

	rgbc_arith u_arith (.clk, .arst_n, .cfg, .win_valid(wv), .win(wd),
		.win_ready(wr), .out_valid(pix_out.valid), .out_data(pix_out.data),
		.out_ready(pix_out.ready));
endmodule
